// ===== src/kdhr_pkg.sv =====
// ----------------------------------------------------------------------------
// kdhr_pkg
// Shared types and constants for the key debounce / hold / repeat block.
// ----------------------------------------------------------------------------
package kdhr_pkg;

    localparam int NUM_KEYS  = 4;
    localparam int TICK_BITS = 10;

    localparam int DEB_W  = 4;
    localparam int HOLD_W = 10;
    localparam int RPT_W  = 10;
    localparam int CMP_W  = (TICK_BITS > HOLD_W) ? TICK_BITS : HOLD_W;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [DEB_W-1:0]     DEBOUNCE_RESET = DEB_W'(2);
    localparam logic [HOLD_W-1:0]    HOLD_RESET     = HOLD_W'(1000 / 10);
    localparam logic [RPT_W-1:0]     REPEAT_RESET   = RPT_W'(250 / 10);
    localparam logic [TICK_BITS-1:0] TICK_MAX       = {TICK_BITS{1'b1}};
    localparam logic [DEB_W-1:0]     STABLE_MAX     = {DEB_W{1'b1}};

    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_HOLD     = 2'd1;
    localparam logic [1:0] REG_REPEAT   = 2'd2;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_PDEB    = 3'd1,
        MODE_PRESSED = 3'd2,
        MODE_REPEAT  = 3'd3,
        MODE_RDEB    = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_PRESS  = 3'd1,
        EV_SHORT  = 3'd2,
        EV_HOLD   = 3'd3,
        EV_REPEAT = 3'd4
    } event_t;

    typedef struct packed {
        logic [DEB_W-1:0]  debounce_scans;
        logic [HOLD_W-1:0] hold_ticks;
        logic [RPT_W-1:0]  repeat_ticks;
    } cfg_t;

endpackage

// ===== src/kdhr_if.sv =====
// ----------------------------------------------------------------------------
// kdhr_key_if / kdhr_event_if
// Valid/ready channels for scan ticks and per-key event results.
// ----------------------------------------------------------------------------
interface kdhr_key_if import kdhr_pkg::*;;
    logic                valid;
    logic                ready;
    logic [NUM_KEYS-1:0] key_pins;

    modport source (output valid, output key_pins, input ready);
    modport sink   (input valid, input key_pins, output ready);
endinterface

interface kdhr_event_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_key0;
    logic [2:0] event_key1;
    logic [2:0] event_key2;
    logic [2:0] event_key3;

    modport source (output valid, output event_key0, output event_key1,
                    output event_key2, output event_key3, input ready);
    modport sink   (input valid, input event_key0, input event_key1,
                    input event_key2, input event_key3, output ready);
endinterface

// ===== src/kdhr_lane.sv =====
// ----------------------------------------------------------------------------
// kdhr_lane
// One key: five-state debounce / hold / repeat machine with elapsed counter.
// ----------------------------------------------------------------------------
module kdhr_lane import kdhr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   advance,
    input  logic   pressed,
    input  cfg_t   cfg,
    output event_t ev
);

    mode_t                mode_reg, mode_next;
    logic                 ret_reg, ret_next;
    logic [DEB_W-1:0]     stable_reg, stable_next;
    logic [TICK_BITS-1:0] elapsed_reg, elapsed_next;

    logic [TICK_BITS-1:0] elapsed_inc;
    logic [DEB_W-1:0]     stable_inc;
    logic                 deb_done;
    logic                 hold_hit;
    logic                 rpt_hit;

    assign elapsed_inc = (elapsed_reg != TICK_MAX) ? elapsed_reg + 1'b1 : elapsed_reg;
    assign stable_inc  = (stable_reg != STABLE_MAX) ? stable_reg + 1'b1 : stable_reg;
    assign deb_done    = stable_inc >= cfg.debounce_scans;
    assign hold_hit    = CMP_W'(elapsed_inc) >= CMP_W'(cfg.hold_ticks);
    assign rpt_hit     = CMP_W'(elapsed_inc) >= CMP_W'(cfg.repeat_ticks);

    always_comb
    begin
        mode_next    = mode_reg;
        ret_next     = ret_reg;
        stable_next  = stable_reg;
        elapsed_next = elapsed_inc;
        ev           = EV_NONE;
        unique case (mode_reg)
            MODE_IDLE:
            begin
                if (pressed)
                begin
                    mode_next   = MODE_PDEB;
                    stable_next = '0;
                end
            end
            MODE_PDEB:
            begin
                stable_next = stable_inc;
                if (deb_done)
                begin
                    if (pressed)
                    begin
                        mode_next    = MODE_PRESSED;
                        elapsed_next = '0;
                        ev           = EV_PRESS;
                    end
                    else
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
            end
            MODE_PRESSED:
            begin
                if (!pressed)
                begin
                    mode_next   = MODE_RDEB;
                    stable_next = '0;
                    ret_next    = 1'b0;
                end
                else if (hold_hit)
                begin
                    mode_next    = MODE_REPEAT;
                    elapsed_next = '0;
                    ret_next     = 1'b0;
                    ev           = EV_HOLD;
                end
            end
            MODE_REPEAT:
            begin
                if (!pressed)
                begin
                    mode_next   = MODE_RDEB;
                    stable_next = '0;
                    ret_next    = 1'b1;
                end
                else if (rpt_hit)
                begin
                    elapsed_next = '0;
                    ev           = EV_REPEAT;
                end
            end
            MODE_RDEB:
            begin
                stable_next = stable_inc;
                if (deb_done)
                begin
                    if (!pressed)
                    begin
                        if (!ret_reg)
                        begin
                            ev = EV_SHORT;
                        end
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        mode_next = ret_reg ? MODE_REPEAT : MODE_PRESSED;
                    end
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            ret_reg     <= 1'b0;
            stable_reg  <= '0;
            elapsed_reg <= '0;
        end
        else if (advance)
        begin
            mode_reg    <= mode_next;
            ret_reg     <= ret_next;
            stable_reg  <= stable_next;
            elapsed_reg <= elapsed_next;
        end
    end

endmodule

// ===== src/kdhr_merge.sv =====
// ----------------------------------------------------------------------------
// kdhr_merge
// Collects the lane events of one tick into the registered result.
// ----------------------------------------------------------------------------
module kdhr_merge import kdhr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  event_t lane_ev [NUM_KEYS],
    output logic   out_valid,
    input  logic   out_ready,
    output event_t out_ev [NUM_KEYS]
);

    logic   valid_reg;
    event_t ev_reg [NUM_KEYS];
    logic   load;

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_ev    = ev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ev_reg <= lane_ev;
        end
    end

endmodule

// ===== src/key_debounce_hold_repeat_top.sv =====
// ----------------------------------------------------------------------------
// key_debounce_hold_repeat_top
// Four-key debouncer with press, short release, hold and auto-repeat events.
// ----------------------------------------------------------------------------
// Usage:
//   key_in carries one scan tick per request: key_pins, bit k low = key k
//   pressed. Every accepted tick produces exactly one request on event_out
//   with a 3-bit code per key (none, press, short release, hold, repeat).
//   Each key has its own lane; the lanes update in the cycle the tick is
//   accepted and their codes land in a single result register.
//   Latency: the result is valid the cycle after the tick is accepted.
//   Throughput: one tick per cycle, set by the result register; key_in.ready
//   stays high while the result register is empty or being drained.
//   If event_out stalls, the result holds and key_in.ready drops until it
//   is taken; lane state advances only on accepted ticks.
//   Reset: all keys idle, counters zero, registers at their defaults
//   (debounce 2, hold 100, repeat 25). No clearing pass is needed.
//   APB: debounce_scans at 0x0, hold_ticks at 0x4, repeat_ticks at 0x8;
//   write only while no tick is in flight.
// ----------------------------------------------------------------------------
module key_debounce_hold_repeat_top import kdhr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    kdhr_key_if.sink             key_in,
    kdhr_event_if.source         event_out,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    cfg_t   cfg_reg;
    logic   cfg_wr;
    logic   advance;
    logic   tick_ready;
    event_t lane_ev [NUM_KEYS];
    event_t out_ev  [NUM_KEYS];

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_scans <= DEBOUNCE_RESET;
            cfg_reg.hold_ticks     <= HOLD_RESET;
            cfg_reg.repeat_ticks   <= REPEAT_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_DEBOUNCE: cfg_reg.debounce_scans <= pwdata[DEB_W-1:0];
                REG_HOLD:     cfg_reg.hold_ticks     <= pwdata[HOLD_W-1:0];
                REG_REPEAT:   cfg_reg.repeat_ticks   <= pwdata[RPT_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_DEBOUNCE: prdata = PDATA_W'(cfg_reg.debounce_scans);
            REG_HOLD:     prdata = PDATA_W'(cfg_reg.hold_ticks);
            REG_REPEAT:   prdata = PDATA_W'(cfg_reg.repeat_ticks);
            default:      prdata = '0;
        endcase
    end

    assign key_in.ready = tick_ready;
    assign advance      = key_in.valid && tick_ready;

    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_lane
        kdhr_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .pressed (!key_in.key_pins[k]),
            .cfg     (cfg_reg),
            .ev      (lane_ev[k])
        );
    end

    kdhr_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (key_in.valid),
        .in_ready  (tick_ready),
        .lane_ev   (lane_ev),
        .out_valid (event_out.valid),
        .out_ready (event_out.ready),
        .out_ev    (out_ev)
    );

    assign event_out.event_key0 = out_ev[0];
    assign event_out.event_key1 = out_ev[1];
    assign event_out.event_key2 = out_ev[2];
    assign event_out.event_key3 = out_ev[3];

endmodule

// ===== src/kdhr_checker.sv =====
// ----------------------------------------------------------------------------
// kdhr_checker
// Port-level checks on the key debounce block, bound to the top level.
// ----------------------------------------------------------------------------
module kdhr_checker import kdhr_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] ev0,
    input logic [2:0] ev1,
    input logic [2:0] ev2,
    input logic [2:0] ev3
);

    a_codes_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (ev0 <= EV_REPEAT) && (ev1 <= EV_REPEAT) &&
                      (ev2 <= EV_REPEAT) && (ev3 <= EV_REPEAT))
        else $error("event code out of range");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ev0) && $stable(ev1) &&
                                    $stable(ev2) && $stable(ev3))
        else $error("stalled result changed");

    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("input stalled while output free");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted request gave no result");

    a_press_once: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && ev0 == EV_PRESS) ##1 (out_valid && out_ready)
        |-> ev0 != EV_PRESS)
        else $error("press on consecutive ticks");

endmodule

bind key_debounce_hold_repeat_top kdhr_checker u_kdhr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (key_in.valid),
    .in_ready  (key_in.ready),
    .out_valid (event_out.valid),
    .out_ready (event_out.ready),
    .ev0       (event_out.event_key0),
    .ev1       (event_out.event_key1),
    .ev2       (event_out.event_key2),
    .ev3       (event_out.event_key3)
);
